[rtl/fat_short_name_formatter_assert.svh]
// Assertion macros for the short-name formatter.
// FSNF_ASSERT is disabled while reset is asserted; FSNF_ASSERT_ALWAYS is checked at every edge.
`ifndef FAT_SHORT_NAME_FORMATTER_ASSERT_SVH
`define FAT_SHORT_NAME_FORMATTER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define FSNF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define FSNF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSNF_ASSERT(lbl, prop, msg)
`define FSNF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/fsnf_pkg.sv]
package fsnf_pkg;

	localparam int unsigned NameLen  = 8;
	localparam int unsigned ExtLen   = 3;
	localparam int unsigned NameBits = NameLen * 8;
	localparam int unsigned ExtBits  = ExtLen * 8;

	localparam logic [7:0] SpaceChar = 8'h20;
	localparam logic [7:0] DotChar   = 8'h2E;
	localparam logic [7:0] CaseGap   = 8'h20;

	typedef struct packed {
		logic [7:0] char_code;
		logic       has_char;
		logic       is_final;
	} item_t;

	function automatic logic [7:0] fold_upper(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - CaseGap;
		end
		return r;
	endfunction

	function automatic logic char_ok(input logic [7:0] c);
		logic ok;
		ok = 1'b0;
		if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39)) begin
			ok = 1'b1;
		end else begin
			unique case (c)
				8'h24, 8'h25, 8'h27, 8'h2D, 8'h5F, 8'h40, 8'h7E, 8'h60,
				8'h21, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5E, 8'h23, 8'h26: ok = 1'b1;
				default: ok = 1'b0;
			endcase
		end
		return ok;
	endfunction

endpackage

[rtl/fsnf_if.sv]
interface fsnf_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       has_char;
	logic       is_final;

	modport source (output valid, output char_code, output has_char, output is_final,
		input ready);
	modport sink (input valid, input char_code, input has_char, input is_final,
		output ready);
endinterface

interface fsnf_name_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [63:0] base_name;
	logic [23:0] extension;

	modport source (output valid, output status, output base_name, output extension,
		input ready);
	modport sink (input valid, input status, input base_name, input extension,
		output ready);
endinterface

[rtl/fat_short_name_formatter.sv]
// A request is first held in the input register; a final request then loads its result
// into the output register once that is free, and the result is taken from there.
// Throughput: one request per cycle; a final request holds off the input only while
// the previous result is still waiting to be taken.
// Reset (arst_n low, asynchronous): both registers empty, counts and flags cleared,
// name and extension filled with spaces.
`include "fat_short_name_formatter_assert.svh"

module fat_short_name_formatter
	import fsnf_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	fsnf_char_if.sink    chars,
	fsnf_name_if.source  names
);

	logic                valid_s1;
	item_t               item_s1;

	logic [NameBits-1:0] name_q;
	logic [ExtBits-1:0]  ext_q;
	logic [3:0]          ncnt_q;
	logic [1:0]          ecnt_q;
	logic                in_ext_q;
	logic                err_q;

	logic [NameBits-1:0] name_d;
	logic [ExtBits-1:0]  ext_d;
	logic [3:0]          ncnt_d;
	logic [1:0]          ecnt_d;
	logic                in_ext_d;
	logic                err_d;
	logic [7:0]          cu;
	logic                bad;

	logic                out_free;
	logic                s1_go;
	logic                take_final;
	logic                state_idle;
	logic                first_blank;
	logic                result_zero;

	assign out_free    = !names.valid || names.ready;
	// a final request needs room in the result register, others always advance
	assign s1_go       = valid_s1 && (!item_s1.is_final || out_free);
	assign chars.ready = !valid_s1 || s1_go;

	assign take_final  = s1_go && item_s1.is_final;
	assign state_idle  = ncnt_q == 4'd0 && ecnt_q == 2'd0 && !in_ext_q && !err_q;
	assign first_blank = names.base_name[NameBits-1 -: 8] == SpaceChar;
	assign result_zero = names.base_name == '0 && names.extension == '0;

	always_comb begin
		cu       = fold_upper(item_s1.char_code);
		name_d   = name_q;
		ext_d    = ext_q;
		ncnt_d   = ncnt_q;
		ecnt_d   = ecnt_q;
		in_ext_d = in_ext_q;
		err_d    = err_q;
		if (item_s1.has_char && !err_q) begin
			priority if (cu == DotChar) begin
				if (in_ext_q || ncnt_q == 4'd0) begin
					err_d = 1'b1;
				end else begin
					in_ext_d = 1'b1;
				end
			end else if (!char_ok(cu)) begin
				err_d = 1'b1;
			end else if (!in_ext_q) begin
				if (ncnt_q >= 4'(NameLen)) begin
					err_d = 1'b1;
				end else begin
					for (int i = 0; i < NameLen; i++) begin
						if (ncnt_q == 4'(i)) begin
							name_d[NameBits-1-8*i -: 8] = cu;
						end
					end
					ncnt_d = ncnt_q + 4'd1;
				end
			end else begin
				if (ecnt_q >= 2'(ExtLen)) begin
					err_d = 1'b1;
				end else begin
					for (int i = 0; i < ExtLen; i++) begin
						if (ecnt_q == 2'(i)) begin
							ext_d[ExtBits-1-8*i -: 8] = cu;
						end
					end
					ecnt_d = ecnt_q + 2'd1;
				end
			end
		end
		bad = err_d || ncnt_d == 4'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			item_s1.char_code <= chars.char_code;
			item_s1.has_char  <= chars.has_char;
			item_s1.is_final  <= chars.is_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_q   <= {NameLen{SpaceChar}};
			ext_q    <= {ExtLen{SpaceChar}};
			ncnt_q   <= 4'd0;
			ecnt_q   <= 2'd0;
			in_ext_q <= 1'b0;
			err_q    <= 1'b0;
		end else if (s1_go) begin
			if (item_s1.is_final) begin
				// clear the component state as the result is loaded
				name_q   <= {NameLen{SpaceChar}};
				ext_q    <= {ExtLen{SpaceChar}};
				ncnt_q   <= 4'd0;
				ecnt_q   <= 2'd0;
				in_ext_q <= 1'b0;
				err_q    <= 1'b0;
			end else begin
				name_q   <= name_d;
				ext_q    <= ext_d;
				ncnt_q   <= ncnt_d;
				ecnt_q   <= ecnt_d;
				in_ext_q <= in_ext_d;
				err_q    <= err_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			names.valid <= 1'b0;
		end else if (out_free) begin
			names.valid <= s1_go && item_s1.is_final;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && item_s1.is_final) begin
			names.status    <= bad;
			names.base_name <= bad ? '0 : name_d;
			names.extension <= bad ? '0 : ext_d;
		end
	end

	`FSNF_ASSERT(a_ncnt_bound, ncnt_q <= 4'(NameLen), "name count above limit")
	`FSNF_ASSERT(a_ext_needs_dot, ecnt_q != 2'd0 |-> in_ext_q, "extension without dot")
	`FSNF_ASSERT(a_final_clears, take_final |=> state_idle, "state not cleared after final")
	`FSNF_ASSERT(a_ok_first_char, names.valid && !names.status |-> !first_blank, "ok result with empty name")
	`FSNF_ASSERT(a_bad_zero, names.valid && names.status |-> result_zero, "error result not zeroed")

endmodule

[dv/fsnf_name_checker.sv]
`timescale 1ns / 1ps

module fsnf_name_checker
	import fsnf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	fsnf_char_if  chars,
	fsnf_name_if  names,
	output int    mismatches,
	output int    names_pending,
	output int    names_checked,
	output int    names_rejected
);

	typedef struct {
		bit        status;
		bit [63:0] base_name;
		bit [23:0] extension;
	} short_name_t;

	short_name_t names_due[$];

	bit [7:0] name_buf [NameLen];
	bit [7:0] ext_buf  [ExtLen];
	int       name_len;
	int       ext_len;
	bit       in_ext;
	bit       bad;

	function automatic bit legal_char(bit [7:0] c);
		if ((c >= "A" && c <= "Z") || (c >= "0" && c <= "9")) begin
			return 1'b1;
		end
		case (c)
			"$", "%", "'", "-", "_", "@", "~", "!",
			"(", ")", "{", "}", "^", "#", "&", 8'h60: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic clear_component();
		foreach (name_buf[i]) name_buf[i] = SpaceChar;
		foreach (ext_buf[i]) ext_buf[i] = SpaceChar;
		name_len = 0;
		ext_len  = 0;
		in_ext   = 1'b0;
		bad      = 1'b0;
	endtask

	task automatic fold_in_char(bit [7:0] raw);
		bit [7:0] c;
		c = raw;
		if (c >= "a" && c <= "z") begin
			c = c - CaseGap;
		end
		// errors stick until the closing request
		if (bad) begin
			return;
		end
		if (c == DotChar) begin
			if (in_ext || name_len == 0) begin
				bad = 1'b1;
			end else begin
				in_ext = 1'b1;
			end
			return;
		end
		if (!legal_char(c)) begin
			bad = 1'b1;
		end else if (!in_ext) begin
			if (name_len >= NameLen) begin
				bad = 1'b1;
			end else begin
				name_buf[name_len] = c;
				name_len++;
			end
		end else begin
			if (ext_len >= ExtLen) begin
				bad = 1'b1;
			end else begin
				ext_buf[ext_len] = c;
				ext_len++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		short_name_t want;
		short_name_t got;
		if (!arst_n) begin
			names_due.delete();
			clear_component();
			mismatches     = 0;
			names_pending  = 0;
			names_checked  = 0;
			names_rejected = 0;
		end else begin
			// results first: they come from earlier requests
			if (names.valid && names.ready) begin
				if (names_due.size() == 0) begin
					$error("unexpected name result: status %0b name %h ext %h",
						names.status, names.base_name, names.extension);
					mismatches++;
				end else begin
					want = names_due.pop_front();
					got.status    = names.status;
					got.base_name = names.base_name;
					got.extension = names.extension;
					names_checked++;
					if (want.status) names_rejected++;
					if (got.status !== want.status) begin
						$error("status: expected %0b, got %0b", want.status, got.status);
						mismatches++;
					end
					if (got.base_name !== want.base_name) begin
						$error("base_name: expected %h, got %h", want.base_name,
							got.base_name);
						mismatches++;
					end
					if (got.extension !== want.extension) begin
						$error("extension: expected %h, got %h", want.extension,
							got.extension);
						mismatches++;
					end
				end
			end
			if (chars.valid && chars.ready) begin
				if (chars.has_char) begin
					fold_in_char(chars.char_code);
				end
				if (chars.is_final) begin
					want.status    = bad || name_len == 0;
					want.base_name = '0;
					want.extension = '0;
					if (!want.status) begin
						foreach (name_buf[i]) want.base_name = {want.base_name[55:0], name_buf[i]};
						foreach (ext_buf[i]) want.extension = {want.extension[15:0], ext_buf[i]};
					end
					names_due.push_back(want);
					clear_component();
				end
			end
			names_pending = names_due.size();
		end
	end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import fsnf_pkg::*;

	logic clk;
	logic arst_n;

	fsnf_char_if chars_bus ();
	fsnf_name_if names_bus ();

	int mismatches;
	int names_pending;
	int names_checked;
	int names_rejected;
	int requests_sent;
	int idle_pct;
	int stall_pct;

	fat_short_name_formatter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_bus.sink),
		.names  (names_bus.source)
	);

	fsnf_name_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.chars          (chars_bus),
		.names          (names_bus),
		.mismatches     (mismatches),
		.names_pending  (names_pending),
		.names_checked  (names_checked),
		.names_rejected (names_rejected)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		names_bus.ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic bit [7:0] pick_legal();
		bit [7:0] punct [16] = '{"$", "%", "'", "-", "_", "@", "~", 8'h60,
			"!", "(", ")", "{", "}", "^", "#", "&"};
		case ($urandom_range(3))
			0: return 8'(8'h41 + $urandom_range(25));
			1: return 8'(8'h61 + $urandom_range(25));
			2: return 8'(8'h30 + $urandom_range(9));
			default: return punct[4'($urandom_range(15))];
		endcase
	endfunction

	// call at a clock edge; returns at the edge that accepts the request
	task automatic push_request(bit [7:0] code, bit has, bit fin);
		while ($urandom_range(99) < idle_pct) begin
			chars_bus.valid <= 1'b0;
			@(posedge clk);
		end
		chars_bus.valid     <= 1'b1;
		chars_bus.char_code <= code;
		chars_bus.has_char  <= has;
		chars_bus.is_final  <= fin;
		@(posedge clk);
		while (!chars_bus.ready) @(posedge clk);
		requests_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			push_request(s[i], 1'b1, i == s.len() - 1);
		end
	endtask

	task automatic send_chars(bit [7:0] q[$], bit close_empty);
		for (int i = 0; i < q.size(); i++) begin
			// drop in an empty request now and then
			if ($urandom_range(11) == 0) begin
				push_request(8'($urandom_range(255)), 1'b0, 1'b0);
			end
			push_request(q[i], 1'b1, !close_empty && i == q.size() - 1);
		end
		if (close_empty || q.size() == 0) begin
			push_request(8'($urandom_range(255)), 1'b0, 1'b1);
		end
	endtask

	task automatic send_random_component();
		bit [7:0] q[$];
		int       kind;
		int       nlen;
		int       elen;
		bit       dot;
		kind = $urandom_range(99);
		if (kind < 80) begin
			if (kind < 70) begin
				nlen = ($urandom_range(3) == 0) ? NameLen : $urandom_range(NameLen, 1);
				elen = $urandom_range(ExtLen);
			end else begin
				// overlong name or extension
				nlen = $urandom_range(1) ? NameLen + 1 : $urandom_range(NameLen, 1);
				elen = (nlen > NameLen) ? $urandom_range(ExtLen) : ExtLen + 1;
			end
			dot = elen > 0 || $urandom_range(3) == 0;
			repeat (nlen) q.push_back(pick_legal());
			if (dot) q.push_back(DotChar);
			repeat (elen) q.push_back(pick_legal());
		end else begin
			repeat ($urandom_range(12)) begin
				case ($urandom_range(9))
					0, 1, 2, 3, 4: q.push_back(pick_legal());
					5, 6: q.push_back(DotChar);
					default: q.push_back(8'($urandom_range(255)));
				endcase
			end
		end
		send_chars(q, $urandom_range(3) == 0);
	endtask

	initial begin
		int idle_plan [4]  = '{0, 64, 0, 20};
		int stall_plan [4] = '{0, 0, 64, 20};
		int guard;

		idle_pct            = 0;
		stall_pct           = 0;
		requests_sent       = 0;
		arst_n              = 1'b0;
		chars_bus.valid     <= 1'b0;
		chars_bus.char_code <= '0;
		chars_bus.has_char  <= 1'b0;
		chars_bus.is_final  <= 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// empty component, then dot handling, folding, a bad byte and overlong name and extension
		push_request(8'hFF, 1'b0, 1'b1);
		push_request("~", 1'b1, 1'b0);
		push_request(8'h00, 1'b0, 1'b0);
		send_text(".a");
		send_text("A.");
		send_text(".");
		send_text("A..");
		push_request(8'hFF, 1'b1, 1'b0);
		push_request("9", 1'b1, 1'b1);
		send_text("abcDEFGHi");
		send_text("B.1234");

		for (int p = 0; p < 4; p++) begin
			idle_pct  = idle_plan[p];
			stall_pct = stall_plan[p];
			while (requests_sent < 28 + (p + 1) * 180) send_random_component();
		end
		chars_bus.valid <= 1'b0;
		stall_pct = 0;

		guard = 0;
		while (names_pending != 0 && guard < 1000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);

		$display("Sent %0d character requests over four pacing phases;", requests_sent);
		$display("checked %0d short names, %0d of them rejected.", names_checked,
			names_rejected);
		if (mismatches == 0 && names_pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/fsnf_pkg.sv
rtl/fsnf_if.sv
rtl/fat_short_name_formatter.sv
dv/fsnf_name_checker.sv
dv/testbench.sv
